// File: hw/rtl/hsvbgr_pkg.sv
// Shared constants and types for the HSV to BGR pixel converter.
package hsvbgr_pkg;

  parameter int unsigned FRAC_BITS_DEF = 16;
  parameter int unsigned HUE_SECTORS   = 6;
  parameter int unsigned CHAN_MAX      = 255;
  parameter int unsigned CHAN_W        = 8;
  parameter int unsigned OUT_TDATA_W   = 3 * CHAN_W;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_e;

endpackage

// File: hw/rtl/hsvbgr_sector.sv
// First stage: input clamp, hue sector and in-sector fraction.
module hsvbgr_sector #(
  parameter int unsigned FRAC_BITS = hsvbgr_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [FRAC_BITS:0]      hue_i,
  input  logic [FRAC_BITS:0]      sat_i,
  input  logic [FRAC_BITS:0]      val_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output hsvbgr_pkg::sector_e     sector_o,
  output logic [FRAC_BITS-1:0]    frac_o,
  output logic [FRAC_BITS:0]      sat_o,
  output logic [FRAC_BITS:0]      val_o
);

  localparam int unsigned H6W = FRAC_BITS + 3;
  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0]   hue_c, sat_c, val_c;
  logic [H6W-1:0]       hue6;
  logic                 advance;
  logic                 valid_q;
  hsvbgr_pkg::sector_e  sector_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [FRAC_BITS:0]   sat_q, val_q;

  always_comb begin
    hue_c = (hue_i > One) ? One : hue_i;
    sat_c = (sat_i > One) ? One : sat_i;
    val_c = (val_i > One) ? One : val_i;
    hue6  = H6W'(hue_c) * H6W'(hsvbgr_pkg::HUE_SECTORS);
  end

  assign advance = !valid_q || ready_i;
  assign ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && valid_i) begin
      sector_q <= hsvbgr_pkg::sector_e'(hue6[FRAC_BITS+2:FRAC_BITS]);
      frac_q   <= hue6[FRAC_BITS-1:0];
      sat_q    <= sat_c;
      val_q    <= val_c;
    end
  end

  assign valid_o  = valid_q;
  assign sector_o = sector_q;
  assign frac_o   = frac_q;
  assign sat_o    = sat_q;
  assign val_o    = val_q;

endmodule

// File: hw/rtl/hsvbgr_prod.sv
// Second and third stages: the p, q and t products.
module hsvbgr_prod #(
  parameter int unsigned FRAC_BITS = hsvbgr_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  hsvbgr_pkg::sector_e     sector_i,
  input  logic [FRAC_BITS-1:0]    frac_i,
  input  logic [FRAC_BITS:0]      sat_i,
  input  logic [FRAC_BITS:0]      val_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output hsvbgr_pkg::sector_e     sector_o,
  output logic [FRAC_BITS:0]      p_o,
  output logic [FRAC_BITS:0]      q_o,
  output logic [FRAC_BITS:0]      t_o,
  output logic [FRAC_BITS:0]      val_o
);

  localparam int unsigned MulW = 2 * FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};

  logic [MulW-1:0]     mul_fs, mul_gfs, mul_p, mul_q, mul_t;
  logic                adv2, adv3;
  logic                valid2_q, valid3_q;
  hsvbgr_pkg::sector_e sec2_q, sec3_q;
  logic [FRAC_BITS:0]  fs_q, gfs_q, p2_q, v2_q;
  logic [FRAC_BITS:0]  p3_q, q3_q, t3_q, v3_q;

  always_comb begin
    mul_fs  = MulW'(frac_i) * MulW'(sat_i);
    mul_gfs = MulW'(One - {1'b0, frac_i}) * MulW'(sat_i);
    mul_p   = MulW'(val_i) * MulW'(One - sat_i);
    mul_q   = MulW'(v2_q) * MulW'(One - fs_q);
    mul_t   = MulW'(v2_q) * MulW'(One - gfs_q);
  end

  assign adv3    = !valid3_q || ready_i;
  assign adv2    = !valid2_q || adv3;
  assign ready_o = adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      if (adv2) begin
        valid2_q <= valid_i;
      end
      if (adv3) begin
        valid3_q <= valid2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && valid_i) begin
      sec2_q <= sector_i;
      fs_q   <= mul_fs[2*FRAC_BITS:FRAC_BITS];
      gfs_q  <= mul_gfs[2*FRAC_BITS:FRAC_BITS];
      p2_q   <= mul_p[2*FRAC_BITS:FRAC_BITS];
      v2_q   <= val_i;
    end
    if (adv3 && valid2_q) begin
      sec3_q <= sec2_q;
      p3_q   <= p2_q;
      q3_q   <= mul_q[2*FRAC_BITS:FRAC_BITS];
      t3_q   <= mul_t[2*FRAC_BITS:FRAC_BITS];
      v3_q   <= v2_q;
    end
  end

  assign valid_o  = valid3_q;
  assign sector_o = sec3_q;
  assign p_o      = p3_q;
  assign q_o      = q3_q;
  assign t_o      = t3_q;
  assign val_o    = v3_q;

endmodule

// File: hw/rtl/hsvbgr_mix.sv
// Last stage: sector channel select, scaling to 8 bits and output register.
module hsvbgr_mix #(
  parameter int unsigned FRAC_BITS = hsvbgr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  hsvbgr_pkg::sector_e             sector_i,
  input  logic [FRAC_BITS:0]              p_i,
  input  logic [FRAC_BITS:0]              q_i,
  input  logic [FRAC_BITS:0]              t_i,
  input  logic [FRAC_BITS:0]              val_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [hsvbgr_pkg::CHAN_W-1:0]   blue_o,
  output logic [hsvbgr_pkg::CHAN_W-1:0]   green_o,
  output logic [hsvbgr_pkg::CHAN_W-1:0]   red_o
);

  localparam int unsigned ScW = FRAC_BITS + hsvbgr_pkg::CHAN_W;
  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0] r_sel, g_sel, b_sel;
  logic [ScW-1:0]     r_sc, g_sc, b_sc;
  logic               advance;
  logic               valid_q;
  logic [hsvbgr_pkg::CHAN_W-1:0] blue_q, green_q, red_q;

  always_comb begin
    case (sector_i)
      hsvbgr_pkg::SEC_RED_YELLOW: begin
        r_sel = val_i; g_sel = t_i;   b_sel = p_i;
      end
      hsvbgr_pkg::SEC_YELLOW_GREEN: begin
        r_sel = q_i;   g_sel = val_i; b_sel = p_i;
      end
      hsvbgr_pkg::SEC_GREEN_CYAN: begin
        r_sel = p_i;   g_sel = val_i; b_sel = t_i;
      end
      hsvbgr_pkg::SEC_CYAN_BLUE: begin
        r_sel = p_i;   g_sel = q_i;   b_sel = val_i;
      end
      hsvbgr_pkg::SEC_BLUE_MAGENTA: begin
        r_sel = t_i;   g_sel = p_i;   b_sel = val_i;
      end
      hsvbgr_pkg::SEC_MAGENTA_RED: begin
        r_sel = val_i; g_sel = p_i;   b_sel = q_i;
      end
      default: begin
        r_sel = One;   g_sel = One;   b_sel = One;
      end
    endcase
    r_sc = ScW'(r_sel) * ScW'(hsvbgr_pkg::CHAN_MAX);
    g_sc = ScW'(g_sel) * ScW'(hsvbgr_pkg::CHAN_MAX);
    b_sc = ScW'(b_sel) * ScW'(hsvbgr_pkg::CHAN_MAX);
  end

  assign advance = !valid_q || ready_i;
  assign ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && valid_i) begin
      red_q   <= r_sc[ScW-1:FRAC_BITS];
      green_q <= g_sc[ScW-1:FRAC_BITS];
      blue_q  <= b_sc[ScW-1:FRAC_BITS];
    end
  end

  assign valid_o = valid_q;
  assign blue_o  = blue_q;
  assign green_o = green_q;
  assign red_o   = red_q;

endmodule

// File: hw/rtl/hsv_to_bgr_pixel.sv
// Top level of the HSV to BGR pixel converter.
//
// Usage:
//   Slave stream carries one HSV pixel per transfer: hue, saturation and
//   value as unsigned fractions with FRAC_BITS fraction bits (1.0 is
//   2^FRAC_BITS; larger codes count as 1.0). Master stream carries one
//   8-bit blue, green, red pixel per transfer.
//   Throughput: one pixel per cycle, no gaps, while the master is ready.
//   The result reaches the master side through four register stages
//   (sector, fraction products, p/q/t products, select and scale), each
//   of which holds one pixel.
//   Reset clears every stage valid bit; the master side shows no data
//   until the first pixel has passed through.
//   When the receiver stalls, the output register holds its pixel and the
//   earlier stages keep filling until each holds a pixel; only then does
//   the slave side drop tready. No pixel is lost or repeated.
//   Hue of exactly 1.0 yields white.
module hsv_to_bgr_pixel #(
  parameter int unsigned FRAC_BITS = hsvbgr_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // hue, saturation, brightness (FRAC_BITS+1 bits each), zero padded
  input  logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // blue_out [7:0], green_out [15:8], red_out [23:16]
  output logic [hsvbgr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned InW = FRAC_BITS + 1;

  logic [FRAC_BITS:0]   hue, saturation, brightness;
  logic                 s1_valid, s1_ready, s3_valid, s3_ready;
  hsvbgr_pkg::sector_e  s1_sector, s3_sector;
  logic [FRAC_BITS-1:0] s1_frac;
  logic [FRAC_BITS:0]   s1_sat, s1_val;
  logic [FRAC_BITS:0]   s3_p, s3_q, s3_t, s3_val;
  logic [hsvbgr_pkg::CHAN_W-1:0] blue_out, green_out, red_out;

  assign hue        = s_axis_tdata[InW-1:0];
  assign saturation = s_axis_tdata[2*InW-1:InW];
  assign brightness = s_axis_tdata[3*InW-1:2*InW];

  hsvbgr_sector #(.FRAC_BITS(FRAC_BITS)) u_sector (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .hue_i    (hue),
    .sat_i    (saturation),
    .val_i    (brightness),
    .valid_o  (s1_valid),
    .ready_i  (s1_ready),
    .sector_o (s1_sector),
    .frac_o   (s1_frac),
    .sat_o    (s1_sat),
    .val_o    (s1_val)
  );

  hsvbgr_prod #(.FRAC_BITS(FRAC_BITS)) u_prod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .ready_o  (s1_ready),
    .sector_i (s1_sector),
    .frac_i   (s1_frac),
    .sat_i    (s1_sat),
    .val_i    (s1_val),
    .valid_o  (s3_valid),
    .ready_i  (s3_ready),
    .sector_o (s3_sector),
    .p_o      (s3_p),
    .q_o      (s3_q),
    .t_o      (s3_t),
    .val_o    (s3_val)
  );

  hsvbgr_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s3_valid),
    .ready_o  (s3_ready),
    .sector_i (s3_sector),
    .p_i      (s3_p),
    .q_i      (s3_q),
    .t_i      (s3_t),
    .val_i    (s3_val),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .blue_o   (blue_out),
    .green_o  (green_out),
    .red_o    (red_out)
  );

  assign m_axis_tdata = {red_out, green_out, blue_out};

endmodule

// File: hw/rtl/hsvbgr_checker.sv
// Port-level checks for the HSV to BGR pixel converter, bound to the top level.
module hsvbgr_checker #(
  parameter int unsigned FRAC_BITS = hsvbgr_pkg::FRAC_BITS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0] s_axis_tdata,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [hsvbgr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};

  logic s_fire;
  logic hue_one;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign hue_one = s_axis_tdata[FRAC_BITS:0] == One;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transfer changed or vanished");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && m_axis_tready) ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid)
    else $error("pixel did not reach the output in time");

  a_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && hue_one && m_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
    ##1 m_axis_tready |=> m_axis_tdata == {hsvbgr_pkg::OUT_TDATA_W{1'b1}})
    else $error("full hue did not give white");

endmodule

bind hsv_to_bgr_pixel hsvbgr_checker #(.FRAC_BITS(FRAC_BITS)) u_hsvbgr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: sim/hsv_to_bgr_pixel_tb.sv
// Self-checking testbench for the HSV to BGR pixel converter stream.
`timescale 1ns / 1ps

module hsv_to_bgr_pixel_tb;

  localparam int unsigned FRAC     = hsvbgr_pkg::FRAC_BITS_DEF;
  localparam int unsigned FIELD_W  = FRAC + 1;
  localparam int unsigned IN_W     = ((3 * FIELD_W + 7) / 8) * 8;
  localparam int unsigned ONE      = 1 << FRAC;
  localparam int unsigned FIELD_MAX = (1 << FIELD_W) - 1;

  typedef logic [FIELD_W-1:0] frac_t;

  typedef struct packed {
    logic [hsvbgr_pkg::CHAN_W-1:0] red;
    logic [hsvbgr_pkg::CHAN_W-1:0] green;
    logic [hsvbgr_pkg::CHAN_W-1:0] blue;
  } bgr_t;

  class bgr_scoreboard;
    bgr_t expected_bgr_q[$];
    int   mismatches;
    int   checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH %s (result %0d)", msg, checked);
      mismatches++;
    endtask

    function longint unsigned clamp_frac(frac_t x);
      return (x > ONE) ? longint'(ONE) : longint'(x);
    endfunction

    function longint unsigned to_chan(longint unsigned x);
      return ((x * hsvbgr_pkg::CHAN_MAX) >> FRAC) & 8'hff;
    endfunction

    function bgr_t predict_bgr(frac_t hue, frac_t sat, frac_t val);
      longint unsigned h, s, v, h6, f, fs, gfs, p, q, t, r, g, b;
      logic [2:0] sector;
      bgr_t res;
      h   = clamp_frac(hue);
      s   = clamp_frac(sat);
      v   = clamp_frac(val);
      h6  = h * hsvbgr_pkg::HUE_SECTORS;
      sector = 3'(h6 >> FRAC);
      f   = h6 & (ONE - 1);
      fs  = (f * s) >> FRAC;
      gfs = ((ONE - f) * s) >> FRAC;
      p   = (v * (ONE - s)) >> FRAC;
      q   = (v * (ONE - fs)) >> FRAC;
      t   = (v * (ONE - gfs)) >> FRAC;
      case (sector)
        hsvbgr_pkg::SEC_RED_YELLOW: begin
          r = v; g = t; b = p;
        end
        hsvbgr_pkg::SEC_YELLOW_GREEN: begin
          r = q; g = v; b = p;
        end
        hsvbgr_pkg::SEC_GREEN_CYAN: begin
          r = p; g = v; b = t;
        end
        hsvbgr_pkg::SEC_CYAN_BLUE: begin
          r = p; g = q; b = v;
        end
        hsvbgr_pkg::SEC_BLUE_MAGENTA: begin
          r = t; g = p; b = v;
        end
        hsvbgr_pkg::SEC_MAGENTA_RED: begin
          r = v; g = p; b = q;
        end
        default: begin
          r = ONE; g = ONE; b = ONE;
        end
      endcase
      res.blue  = hsvbgr_pkg::CHAN_W'(to_chan(b));
      res.green = hsvbgr_pkg::CHAN_W'(to_chan(g));
      res.red   = hsvbgr_pkg::CHAN_W'(to_chan(r));
      return res;
    endfunction

    function void note_pixel(frac_t hue, frac_t sat, frac_t val);
      expected_bgr_q.insert(expected_bgr_q.size(), predict_bgr(hue, sat, val));
    endfunction

    task check_bgr(bgr_t got);
      bgr_t want;
      if (expected_bgr_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result b=%0d g=%0d r=%0d",
                                  got.blue, got.green, got.red));
        return;
      end
      want = expected_bgr_q.pop_front();
      if (got.blue !== want.blue)
        report_mismatch($sformatf("blue_out: got %0d expected %0d", got.blue, want.blue));
      if (got.green !== want.green)
        report_mismatch($sformatf("green_out: got %0d expected %0d", got.green, want.green));
      if (got.red !== want.red)
        report_mismatch($sformatf("red_out: got %0d expected %0d", got.red, want.red));
      checked++;
    endtask

    function int pending();
      return expected_bgr_q.size();
    endfunction

    task flush_leftovers();
      while (expected_bgr_q.size() != 0) begin
        void'(expected_bgr_q.pop_front());
        report_mismatch("expected result never arrived");
      end
    endtask
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  // hue, saturation, brightness, zero padded
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  // blue_out, green_out, red_out
  logic [hsvbgr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  bgr_scoreboard sb = new();
  bit  no_idle  = 1'b0;
  bit  hold_req = 1'b0;
  int  pixels_sent = 0;

  hsv_to_bgr_pixel u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // note accepted pixels before checking results on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_pixel(s_axis_tdata[FIELD_W-1:0], s_axis_tdata[2*FIELD_W-1:FIELD_W],
                      s_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_bgr(bgr_t'(m_axis_tdata));
    end
  end

  // receiver: random backpressure, long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 32);
      end
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned rand_frac();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return 0;
    if (pick < 16) return ONE;
    if (pick < 26) return $urandom_range(FIELD_MAX);
    return $urandom_range(ONE - 1);
  endfunction

  task automatic send_pixel(input int unsigned hue, input int unsigned sat,
                            input int unsigned val);
    while (!no_idle && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({frac_t'(val), frac_t'(sat), frac_t'(hue)});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of each field and out-of-range codes
    send_pixel(0, 0, 0);
    send_pixel(0, ONE, ONE);
    send_pixel(ONE, ONE, ONE);
    send_pixel(FIELD_MAX, 0, 0);
    send_pixel(ONE - 1, ONE, ONE);
    send_pixel(12345, FIELD_MAX, FIELD_MAX);
    send_pixel(40000, ONE, 0);
    send_pixel(ONE + 1, 30000, 20000);
    // each sector, both sides of every boundary
    send_pixel(5000, 45000, 50000);
    send_pixel(10922, 45000, 50000);
    send_pixel(10923, 45000, 50000);
    send_pixel(16000, 45000, 50000);
    send_pixel(21845, 45000, 50000);
    send_pixel(21846, 45000, 50000);
    send_pixel(32767, 45000, 50000);
    send_pixel(32768, 45000, 50000);
    send_pixel(43690, 45000, 50000);
    send_pixel(43691, 45000, 50000);
    send_pixel(54613, 45000, 50000);
    send_pixel(54614, 45000, 50000);
    send_pixel(60000, 65535, 65535);
    send_pixel(20000, 1, 1);
    drain_results();

    // back-to-back, no idling on either side
    no_idle = 1'b1;
    repeat (150) send_pixel(rand_frac(), rand_frac(), rand_frac());

    // stall the output long enough to back up the pipeline
    hold_req = 1'b1;
    repeat (150) send_pixel(rand_frac(), rand_frac(), rand_frac());
    no_idle = 1'b0;
    drain_results();

    repeat (300) send_pixel(rand_frac(), rand_frac(), rand_frac());
    drain_results();
    repeat (10) @(posedge clk_i);
    sb.flush_leftovers();

    $display("Sent %0d pixels, checked %0d results: field extremes, out-of-range codes,",
             pixels_sent, sb.checked);
    $display("all six hue sectors and boundaries, random gaps, a long output stall, drains.");
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
